// ----- rtl/bpmdt_pkg.sv -----
package bpmdt_pkg;

    // Widths fixed by the item formats.
    localparam int COST_W     = 20;
    localparam int LBL_W      = 6;
    localparam int TOFF_W     = 18;
    localparam int SLOPE_W    = 12;
    localparam int TOTAL_W    = 26;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // Default label count of one message.
    localparam int LABELS_DEF = 64;

    typedef logic signed [COST_W-1:0]  t_cost;
    typedef logic [LBL_W-1:0]          t_label;
    typedef logic signed [TOTAL_W-1:0] t_total;

    localparam t_cost COST_MAX = 20'sh7FFFF;
    localparam t_cost COST_MIN = 20'sh80000;

    // Register reset values: 55.0 and 1.0 in Q.4.
    localparam logic [TOFF_W-1:0]  TOFF_RST  = 18'd880;
    localparam logic [SLOPE_W-1:0] SLOPE_RST = 12'd16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRUNC_OFFSET = 1'b0,
        REG_STEP_SLOPE   = 1'b1
    } t_cfg_reg;

    // Operation carried by a memory read through the datapath stage.
    typedef enum logic [1:0] {
        OP_FWD,
        OP_BWD,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FWD,
        ST_BWD,
        ST_SETTLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load_en;
        logic   rd_en;
        t_op    op;
        logic   first;
        t_label addr;
        logic   div_start;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stage_free;
        logic acc_busy;
        logic div_done;
    } t_stat;

endpackage

// ----- rtl/bpmdt_in_if.sv -----
interface bpmdt_in_if import bpmdt_pkg::*; ();

    logic  valid;
    logic  ready;
    t_cost cost_a;
    t_cost cost_b;
    t_cost cost_c;
    t_cost cost_d;

    modport source (output valid, output cost_a, output cost_b, output cost_c,
                    output cost_d, input ready);
    modport sink (input valid, input cost_a, input cost_b, input cost_c,
                  input cost_d, output ready);

endinterface

// ----- rtl/bpmdt_out_if.sv -----
interface bpmdt_out_if import bpmdt_pkg::*; ();

    logic   valid;
    logic   ready;
    t_cost  message_value;
    t_label label_index;
    logic   last_label;

    modport source (output valid, output message_value, output label_index,
                    output last_label, input ready);
    modport sink (input valid, input message_value, input label_index,
                  input last_label, output ready);

endinterface

// ----- rtl/bpmdt_ctrl.sv -----
module bpmdt_ctrl import bpmdt_pkg::*; #(
    parameter int LABELS = LABELS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    localparam int AW = $clog2(LABELS);
    localparam logic [AW-1:0] LAST = AW'(LABELS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;

    // State and label counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = OP_FWD;
        o_cmd.addr = LBL_W'(r_cnt);
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_en = 1'b1;
                    if (r_cnt == LAST) begin
                        n_cnt   = '0;
                        n_state = ST_FWD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_FWD: begin
                if (i_stat.stage_free) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.op    = OP_FWD;
                    o_cmd.first = (r_cnt == '0);
                    if (r_cnt == LAST) begin
                        n_state = ST_BWD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_BWD: begin
                if (i_stat.stage_free) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.op    = OP_BWD;
                    o_cmd.first = (r_cnt == LAST);
                    if (r_cnt == '0) begin
                        n_state = ST_SETTLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            ST_SETTLE: begin
                // Wait until the last clipped value is in the total.
                if (!i_stat.acc_busy) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.stage_free) begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.op    = OP_EMIT;
                    if (r_cnt == LAST) begin
                        n_cnt   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
                n_cnt   = '0;
            end
        endcase
    end

endmodule

// ----- rtl/bpmdt_div.sv -----
module bpmdt_div import bpmdt_pkg::*; #(
    parameter int LABELS = LABELS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_total i_total,
    output logic   o_done,
    output t_cost  o_mean
);

    // Scaled reciprocal of LABELS. Multiplying by it and dropping SHIFT bits gives
    // the exact floor quotient for any magnitude below 2**TOTAL_W.
    localparam int     LW      = $clog2(LABELS);
    localparam int     SHIFT   = TOTAL_W + LW;
    localparam int     RW      = TOTAL_W + 1;
    localparam int     PW      = TOTAL_W + RW;
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(LABELS) - 1)
                                 / longint'(LABELS);
    localparam logic [RW-1:0]      RECIP = RW'(RECIP_L);
    localparam logic [TOTAL_W-1:0] BIAS  = TOTAL_W'(LABELS - 1);

    logic                r_mag_vld;
    logic                r_prod_vld;
    logic                r_neg;
    logic [TOTAL_W-1:0]  r_mag;
    logic [PW-1:0]       r_prod;
    logic [TOTAL_W-1:0]  w_quo;
    logic [TOTAL_W-1:0]  w_mean_full;

    // Stage flags: the magnitude, then the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_vld  <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_mag_vld  <= i_start;
            r_prod_vld <= r_mag_vld;
        end
    end

    // A negative total takes the ceiling of its magnitude, so that the negated
    // quotient is the floor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_total[TOTAL_W-1];
            r_mag <= i_total[TOTAL_W-1] ? TOTAL_W'(-i_total) + BIAS : TOTAL_W'(i_total);
        end
        if (r_mag_vld) begin
            r_prod <= r_mag * RECIP;
        end
    end

    // Quotient of the magnitude, with the sign put back.
    assign w_quo       = TOTAL_W'(r_prod >> SHIFT);
    assign w_mean_full = r_neg ? -w_quo : w_quo;

    assign o_done = r_prod_vld;
    assign o_mean = w_mean_full[COST_W-1:0];

endmodule

// ----- rtl/bpmdt_dp.sv -----
module bpmdt_dp import bpmdt_pkg::*; #(
    parameter int LABELS = LABELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  t_cost              i_cost_a,
    input  t_cost              i_cost_b,
    input  t_cost              i_cost_c,
    input  t_cost              i_cost_d,
    input  logic [TOFF_W-1:0]  i_trunc_offset,
    input  logic [SLOPE_W-1:0] i_step_slope,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output t_cost              o_message_value,
    output t_label             o_label_index,
    output logic               o_last_label
);

    localparam int AW = $clog2(LABELS);
    localparam int WW = COST_W + 2;
    localparam logic [AW-1:0] LAST = AW'(LABELS - 1);
    localparam logic signed [WW-1:0] SAT_HI = WW'(COST_MAX);
    localparam logic signed [WW-1:0] SAT_LO = WW'(COST_MIN);

    function automatic t_cost sat_cost(input logic signed [WW-1:0] v);
        t_cost res;
        if (v > SAT_HI) begin
            res = COST_MAX;
        end else if (v < SAT_LO) begin
            res = COST_MIN;
        end else begin
            res = v[COST_W-1:0];
        end
        return res;
    endfunction

    t_cost           r_mem [0:LABELS-1];
    t_cost           r_rd_data;

    logic            r_ld_vld;
    logic [AW-1:0]   r_ld_addr;
    t_cost           r_ld_val;
    t_cost           r_min;
    t_cost           r_limit;

    logic            r_p_vld;
    logic [AW-1:0]   r_p_addr;
    t_op             r_p_op;
    logic            r_p_first;
    t_cost           r_carry;

    logic            r_clip_vld;
    logic            r_clip_first;
    t_cost           r_clip;
    t_total          r_total;
    t_cost           r_mean;

    logic            r_o_vld;
    t_cost           r_o_value;
    t_label          r_o_label;
    logic            r_o_last;

    logic signed [WW-1:0] w_sum;
    logic signed [WW-1:0] w_lim_sum;
    logic signed [WW-1:0] w_step_sum;
    logic signed [WW-1:0] w_diff;
    t_cost           w_step;
    t_cost           w_env;
    t_cost           w_bval;
    t_cost           w_clip;
    logic            w_out_free;
    logic            w_stage_free;
    logic            w_emit;
    logic            w_wr_en;
    t_cost           w_wr_val;
    logic            w_carry_ld;
    t_cost           w_carry_val;
    logic            w_clip_ld;
    logic            w_div_done;
    t_cost           w_div_mean;

    // Four-way sum of an accepted item, saturated and registered.
    assign w_sum = WW'(i_cost_a) + WW'(i_cost_b) + WW'(i_cost_c) + WW'(i_cost_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_vld <= 1'b0;
        end else begin
            r_ld_vld <= i_cmd.load_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_addr <= i_cmd.addr[AW-1:0];
        r_ld_val  <= sat_cost(w_sum);
    end

    // Running minimum; back to the largest value once the total is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= COST_MAX;
        end else if (i_cmd.div_start) begin
            r_min <= COST_MAX;
        end else if (r_ld_vld && (r_ld_val < r_min)) begin
            r_min <= r_ld_val;
        end
    end

    // Truncation limit follows the minimum and is settled by the backward pass.
    assign w_lim_sum = WW'(r_min) + $signed(WW'(i_trunc_offset));

    always_ff @(posedge i_clk) begin
        r_limit <= sat_cost(w_lim_sum);
    end

    // The read stage holds only while an emitted value waits for the output.
    assign w_out_free   = !r_o_vld || i_out_ready;
    assign w_stage_free = !(r_p_vld && (r_p_op == OP_EMIT)) || w_out_free;
    assign w_emit       = r_p_vld && (r_p_op == OP_EMIT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (w_stage_free) begin
            r_p_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stage_free) begin
            r_p_addr  <= i_cmd.addr[AW-1:0];
            r_p_op    <= i_cmd.op;
            r_p_first <= i_cmd.first;
        end
    end

    // Label cost memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_ld_vld) begin
            r_mem[r_ld_addr] <= r_ld_val;
        end else if (w_wr_en) begin
            r_mem[r_p_addr] <= w_wr_val;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.addr[AW-1:0]];
        end
    end

    // Envelope step: neighbor plus slope, saturated, against the stored value.
    assign w_step_sum = WW'(r_carry) + $signed(WW'(i_step_slope));
    assign w_step     = sat_cost(w_step_sum);
    assign w_env      = (w_step < r_rd_data) ? w_step : r_rd_data;
    assign w_bval     = r_p_first ? r_carry : w_env;
    assign w_clip     = (r_limit < w_bval) ? r_limit : w_bval;

    always_comb begin
        w_wr_en     = 1'b0;
        w_wr_val    = w_env;
        w_carry_ld  = 1'b0;
        w_carry_val = w_env;
        w_clip_ld   = 1'b0;
        if (r_p_vld) begin
            case (r_p_op)
                OP_FWD: begin
                    w_carry_ld = 1'b1;
                    if (r_p_first) begin
                        w_carry_val = r_rd_data;
                    end else begin
                        w_wr_en = 1'b1;
                    end
                end
                OP_BWD: begin
                    // The chain runs on unclipped values; memory gets the clipped one.
                    w_carry_ld  = 1'b1;
                    w_carry_val = w_bval;
                    w_wr_en     = 1'b1;
                    w_wr_val    = w_clip;
                    w_clip_ld   = 1'b1;
                end
                OP_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_carry_ld) begin
            r_carry <= w_carry_val;
        end
    end

    // Clipped values are registered, then summed into the total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_vld <= 1'b0;
        end else begin
            r_clip_vld <= w_clip_ld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clip_ld) begin
            r_clip       <= w_clip;
            r_clip_first <= r_p_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (r_clip_vld) begin
            r_total <= r_clip_first ? TOTAL_W'(r_clip) : r_total + TOTAL_W'(r_clip);
        end
    end

    // Floor of the mean.
    bpmdt_div #(
        .LABELS (LABELS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_total (r_total),
        .o_done  (w_div_done),
        .o_mean  (w_div_mean)
    );

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_mean <= w_div_mean;
        end
    end

    // Normalize and hold the result until the transfer.
    assign w_diff = WW'(r_rd_data) - WW'(r_mean);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_emit) begin
            r_o_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_value <= sat_cost(w_diff);
            r_o_label <= LBL_W'(r_p_addr);
            r_o_last  <= (r_p_addr == LAST);
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_message_value = r_o_value;
    assign o_label_index   = r_o_label;
    assign o_last_label    = r_o_last;

    assign o_stat.stage_free = w_stage_free;
    assign o_stat.acc_busy   = r_p_vld || r_clip_vld;
    assign o_stat.div_done   = w_div_done;

endmodule

// ----- rtl/bp_message_distance_transform_core.sv -----
// Belief-propagation message with a linear cost truncated at a discontinuity.
// Input channel i_in: one transfer per label, in label order from label 0,
// carrying the four incoming costs (signed Q15.4). The block sums them with
// saturation and stores the result; after the LABELS-th transfer it runs a
// forward and a backward envelope pass, clips at minimum plus trunc_offset,
// subtracts the floor of the mean and sends LABELS transfers on o_out, each
// with its label index and a last flag on the final label.
// Sequence per message: loading (one label a cycle while i_in is valid), a
// forward and a backward envelope pass, finishing the total, the mean (a
// reciprocal multiplication on the magnitude of the total), then output of
// LABELS values. The label memory, with one read and one write port,
// handles one label a cycle in every pass unless a stall on o_out holds it.
// Input is taken only while loading. A stall on o_out holds the output
// register and the read stage behind it; the next message may still be
// loaded while the last value waits.
// The configuration port writes a register at an edge with i_cfg_we high.
// Reset (synchronous, active low) returns to loading with an empty message
// and restores the register defaults.
module bp_message_distance_transform_core import bpmdt_pkg::*; #(
    parameter int LABELS = LABELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpmdt_in_if.sink              i_in,
    bpmdt_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [TOFF_W-1:0]  r_trunc_offset;
    logic [SLOPE_W-1:0] r_step_slope;
    t_cmd               w_cmd;
    t_stat              w_stat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trunc_offset <= TOFF_RST;
            r_step_slope   <= SLOPE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_TRUNC_OFFSET: r_trunc_offset <= i_cfg_data[TOFF_W-1:0];
                REG_STEP_SLOPE:   r_step_slope   <= i_cfg_data[SLOPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bpmdt_ctrl #(
        .LABELS (LABELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    bpmdt_dp #(
        .LABELS (LABELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cost_a        (i_in.cost_a),
        .i_cost_b        (i_in.cost_b),
        .i_cost_c        (i_in.cost_c),
        .i_cost_d        (i_in.cost_d),
        .i_trunc_offset  (r_trunc_offset),
        .i_step_slope    (r_step_slope),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_message_value (o_out.message_value),
        .o_label_index   (o_out.label_index),
        .o_last_label    (o_out.last_label)
    );

`ifndef ASSERT_OFF
    // The last flag marks exactly the final label.
    a_last_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_label == (o_out.label_index == LBL_W'(LABELS - 1))))
        else $error("last_label does not match label_index");

    // A memory read is issued only when the read stage can take it.
    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_en |-> w_stat.stage_free)
        else $error("read issued while the read stage is stalled");

    // The divider starts only on a finished total.
    a_div_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.acc_busy)
        else $error("mean started before the total settled");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import bpmdt_pkg::*;

    localparam int NUM_LABELS = LABELS_DEF;
    localparam int NUM_MESSAGES = 5;
    localparam int QUIET_LIMIT = 4000;
    localparam int REPORT_LIMIT = 40;

    // The four incoming costs of one label.
    typedef struct packed {
        t_cost a;
        t_cost b;
        t_cost c;
        t_cost d;
    } t_cost_set;

    // One outgoing message value as the block should send it.
    typedef struct packed {
        t_cost  value;
        t_label label;
        logic   last;
    } t_msg_value;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bpmdt_in_if  in_ch ();
    bpmdt_out_if out_ch ();

    bp_message_distance_transform_core #(
        .LABELS (NUM_LABELS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Pending label costs, and the message values still owed by the block.
    t_cost_set  label_queue[$];
    t_msg_value owed_values[$];
    int items_queued;
    int items_taken = 0;
    int error_count = 0;
    bit idling_on;

    // Our own copy of the registers and the message state.
    int    trunc_cfg;
    int    slope_cfg;
    t_cost label_sums[NUM_LABELS];
    int    labels_seen = 0;
    t_cost message_min = COST_MAX;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_cost clamp_cost(input longint v);
        if (v > longint'(COST_MAX)) return COST_MAX;
        if (v < longint'(COST_MIN)) return COST_MIN;
        return t_cost'(v);
    endfunction

    // Take one label's costs; once the message is complete, work out every value it sends.
    task automatic absorb_label(input t_cost_set cs);
        longint total;
        longint mean;
        t_cost  limit;
        t_cost  stepped;
        t_msg_value res;
        total = longint'(cs.a) + longint'(cs.b) + longint'(cs.c) + longint'(cs.d);
        label_sums[labels_seen] = clamp_cost(total);
        if (label_sums[labels_seen] < message_min) message_min = label_sums[labels_seen];
        labels_seen++;
        if (labels_seen < NUM_LABELS) return;

        // Forward and backward lower envelope.
        for (int q = 1; q < NUM_LABELS; q++) begin
            stepped = clamp_cost(longint'(label_sums[q-1]) + longint'(slope_cfg));
            if (stepped < label_sums[q]) label_sums[q] = stepped;
        end
        for (int q = NUM_LABELS - 2; q >= 0; q--) begin
            stepped = clamp_cost(longint'(label_sums[q+1]) + longint'(slope_cfg));
            if (stepped < label_sums[q]) label_sums[q] = stepped;
        end

        // Truncate at minimum plus offset, and total what remains.
        limit = clamp_cost(longint'(message_min) + longint'(trunc_cfg));
        total = 0;
        for (int q = 0; q < NUM_LABELS; q++) begin
            if (limit < label_sums[q]) label_sums[q] = limit;
            total += longint'(label_sums[q]);
        end

        // Floor of the mean; division here truncates toward zero.
        mean = total / NUM_LABELS;
        if ((total % NUM_LABELS) != 0 && total < 0) mean--;

        for (int q = 0; q < NUM_LABELS; q++) begin
            res.value = clamp_cost(longint'(label_sums[q]) - mean);
            res.label = t_label'(q);
            res.last  = (q == NUM_LABELS - 1);
            owed_values.push_back(res);
        end
        labels_seen = 0;
        message_min = COST_MAX;
    endtask

    // Input driver: one transfer per label, with random bursts of idle cycles.
    int        send_gap;
    t_cost_set next_set;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            in_ch.cost_a <= '0;
            in_ch.cost_b <= '0;
            in_ch.cost_c <= '0;
            in_ch.cost_d <= '0;
            send_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_label({in_ch.cost_a, in_ch.cost_b, in_ch.cost_c, in_ch.cost_d});
                items_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (label_queue.size() > 0 && idling_on
                             && $urandom_range(0, 7) == 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap <= $urandom_range(0, 3);
                end else if (label_queue.size() > 0) begin
                    next_set = label_queue.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.cost_a <= next_set.a;
                    in_ch.cost_b <= next_set.b;
                    in_ch.cost_c <= next_set.c;
                    in_ch.cost_d <= next_set.d;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: random stall bursts, and a field-by-field check of each transfer.
    int         stall_gap;
    t_msg_value wanted;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (owed_values.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $error("unexpected transfer: label_index %0d message_value %0d",
                               out_ch.label_index, out_ch.message_value);
                end else begin
                    wanted = owed_values.pop_front();
                    if (out_ch.message_value !== wanted.value) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $error("message_value: expected %0d, got %0d",
                                   wanted.value, out_ch.message_value);
                    end
                    if (out_ch.label_index !== wanted.label) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $error("label_index: expected %0d, got %0d",
                                   wanted.label, out_ch.label_index);
                    end
                    if (out_ch.last_label !== wanted.last) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $error("last_label: expected %0d, got %0d",
                                   wanted.last, out_ch.last_label);
                    end
                end
            end
            if (stall_gap > 0) begin
                out_ch.ready <= 1'b0;
                stall_gap <= stall_gap - 1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                stall_gap <= $urandom_range(0, 3);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    int quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write both registers; only called while the block is idle.
    task automatic program_registers(input int toff, input int slope);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TRUNC_OFFSET;
        cfg_data  <= CFG_DATA_W'(toff);
        @(posedge i_clk);
        cfg_index <= REG_STEP_SLOPE;
        cfg_data  <= CFG_DATA_W'(slope);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        trunc_cfg = toff;
        slope_cfg = slope;
    endtask

    // Hold off until every queued label is taken and every owed value has come back.
    task automatic wait_until_drained();
        while (!(items_taken == items_queued && owed_values.size() == 0))
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_cost mixed_cost();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 4) return t_cost'($urandom);
        if (pick <= 7) return t_cost'(int'($urandom_range(0, 4095)) - 2048);
        if (pick == 8) return COST_MAX;
        return COST_MIN;
    endfunction

    // Directed labels at the head of the first message: saturation both ways,
    // zero, near-cancelling extremes and alternating bit patterns.
    function automatic t_cost_set directed_label(input int k);
        case (k)
            0, 1:    return {COST_MAX, COST_MAX, COST_MAX, COST_MAX};
            2, 3:    return {COST_MIN, COST_MIN, COST_MIN, COST_MIN};
            4:       return '0;
            5:       return {COST_MAX, COST_MIN, t_cost'(0), t_cost'(0)};
            6:       return {COST_MIN, COST_MAX, COST_MIN, COST_MAX};
            7:       return {COST_MAX, COST_MAX, COST_MIN, t_cost'(0)};
            8:       return {COST_MAX, t_cost'(1), t_cost'(0), t_cost'(0)};
            9:       return {COST_MIN, t_cost'(-1), t_cost'(0), t_cost'(0)};
            10:      return {t_cost'(20'h55555), t_cost'(20'hAAAAA),
                             t_cost'(20'h55555), t_cost'(20'hAAAAA)};
            11:      return {t_cost'(20'hAAAAA), t_cost'(20'h55555),
                             t_cost'(20'hAAAAA), t_cost'(20'h55555)};
            default: return {t_cost'(1), t_cost'(-1), t_cost'(16), t_cost'(-16)};
        endcase
    endfunction

    // Stimulus: one message per phase, with the registers rewritten before every phase but the fourth.
    initial begin : stimulus
        t_cost_set cs;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_TRUNC_OFFSET;
        cfg_data     = '0;
        items_queued = 0;
        idling_on    = 1'b1;
        trunc_cfg    = int'(TOFF_RST);
        slope_cfg    = int'(SLOPE_RST);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        for (int m = 0; m < NUM_MESSAGES; m++) begin
            // The fourth message follows the third with no pause, so the
            // block loads it while the previous values are still going out.
            if (m != 3) wait_until_drained();
            case (m)
                0: program_registers(int'(TOFF_RST), int'(SLOPE_RST));
                1: program_registers(0, 0);
                2: program_registers(262143, 4095);
                4: program_registers($urandom_range(0, 262143), $urandom_range(0, 4095));
                default: ;
            endcase
            // The last message runs with both sides always willing.
            idling_on = (m != NUM_MESSAGES - 1);
            for (int k = 0; k < NUM_LABELS; k++) begin
                if (m == 0 && k < 13) begin
                    cs = directed_label(k);
                end else if (m == 2) begin
                    // Large positive sums: the minimum plus the offset overflows.
                    cs.a = t_cost'($urandom_range(65600, 200000));
                    cs.b = t_cost'($urandom_range(65600, 200000));
                    cs.c = t_cost'($urandom_range(65600, 200000));
                    cs.d = t_cost'($urandom_range(65600, 200000));
                end else if (m == 4) begin
                    cs.a = t_cost'(int'($urandom_range(0, 4095)) - 2048);
                    cs.b = t_cost'(int'($urandom_range(0, 4095)) - 2048);
                    cs.c = t_cost'(int'($urandom_range(0, 4095)) - 2048);
                    cs.d = mixed_cost();
                end else begin
                    cs.a = mixed_cost();
                    cs.b = mixed_cost();
                    cs.c = mixed_cost();
                    cs.d = mixed_cost();
                end
                label_queue.push_back(cs);
                items_queued++;
            end
        end

        wait_until_drained();
        repeat (16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
